### design/als_pkg.sv
package als_pkg;

   localparam int AREA_BYTES_DEF = 65536;
   localparam int OFS_W          = 16;
   localparam int SUM_W          = 18;
   localparam int RSIZE_W        = 15;
   localparam int WORD_W         = 32;
   localparam int CSR_IDX_W      = 1;

   localparam logic [RSIZE_W-1:0] RSIZE_RESET = 15'd64;
   localparam logic [WORD_W-1:0]  MAGIC_RESET = 32'h4C55_4C5A;
   localparam logic [WORD_W-1:0]  ALL_ONES    = 32'hFFFF_FFFF;
   localparam logic [SUM_W-1:0]   DELIM_BYTES = 18'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_RECORD_SIZE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAGIC       = 1'b1;

   typedef enum logic [2:0] {
      ST_CONTINUE   = 3'd0,
      ST_FOUND_ROOM = 3'd1,
      ST_FOUND_FULL = 3'd2,
      ST_EMPTY      = 3'd3,
      ST_BAD_DELIM  = 3'd4,
      ST_NO_TERM    = 3'd5
   } status_type;

   typedef struct packed {
      logic [OFS_W-1:0] scan_offset;
      logic [OFS_W-1:0] last_offset;
      logic             have_record;
   } scan_state_type;

   typedef struct packed {
      status_type       status;
      logic [OFS_W-1:0] next_read_offset;
      logic [OFS_W-1:0] record_offset;
      logic [OFS_W-1:0] append_offset;
   } scan_result_type;

endpackage

### design/append_log_slot_scanner.sv
// Append-log slot scanner: takes one delimiter word per cycle on the req channel and
// returns one rsp word per request in the cycle after acceptance. The decision for a word
// (limit check, all-ones and magic compares, the adds) finishes within the accepting cycle
// and the scan state updates at the same edge, so the next word is accepted directly
// after; the output register is the only storage on the path, and req_stall follows
// rsp_stall only while that register holds an untaken result. Registers: index 0 is
// record_size (bits 14:0 of the data), index 1 is delimiter_magic. Write them only while
// no request is outstanding. After every final status the scan restarts at offset 0.
module append_log_slot_scanner import als_pkg::*; #(
   parameter int AREA_BYTES = AREA_BYTES_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [WORD_W-1:0]    req_delimiter_word,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [2:0]           rsp_status,
   output logic [OFS_W-1:0]     rsp_next_read_offset,
   output logic [OFS_W-1:0]     rsp_record_offset,
   output logic [OFS_W-1:0]     rsp_append_offset,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [WORD_W-1:0]    csr_wdata
);

   logic [RSIZE_W-1:0] record_size_ff;
   logic [WORD_W-1:0]  magic_ff;
   scan_state_type     state_ff;
   scan_state_type     state_in;
   scan_result_type    result_in;
   scan_result_type    result_ff;
   logic               rsp_valid_ff;
   logic               accept;

   als_step #(.AREA_BYTES(AREA_BYTES)) u_step (
      .word        (req_delimiter_word),
      .record_size (record_size_ff),
      .magic       (magic_ff),
      .state_cur   (state_ff),
      .state_next  (state_in),
      .result      (result_in)
   );

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         record_size_ff <= RSIZE_RESET;
         magic_ff       <= MAGIC_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_RECORD_SIZE: record_size_ff <= csr_wdata[RSIZE_W-1:0];
            CSR_MAGIC:       magic_ff       <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            state_ff <= state_in;
         end
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // result word holds while stalled
   always_ff @(posedge clock) begin
      if (accept) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = result_ff.status;
   assign rsp_next_read_offset = result_ff.next_read_offset;
   assign rsp_record_offset    = result_ff.record_offset;
   assign rsp_append_offset    = result_ff.append_offset;

endmodule

### design/als_step.sv
module als_step import als_pkg::*; #(
   parameter int AREA_BYTES = AREA_BYTES_DEF
) (
   input  logic [WORD_W-1:0]  word,
   input  logic [RSIZE_W-1:0] record_size,
   input  logic [WORD_W-1:0]  magic,
   input  scan_state_type     state_cur,
   output scan_state_type     state_next,
   output scan_result_type    result
);

   localparam logic [SUM_W-1:0] AREA = SUM_W'(AREA_BYTES);

   logic [SUM_W-1:0] stride;
   logic [SUM_W-1:0] slot_end;
   logic [SUM_W-1:0] next_end;
   logic [SUM_W-1:0] write_ofs;
   logic [SUM_W-1:0] write_end;

   assign stride    = DELIM_BYTES + SUM_W'(record_size);
   assign slot_end  = SUM_W'(state_cur.scan_offset) + stride;
   assign next_end  = slot_end + stride;
   assign write_ofs = SUM_W'(state_cur.last_offset) + stride;
   assign write_end = write_ofs + stride;

   always_comb begin
      state_next = '0;
      result     = '{status: ST_NO_TERM, next_read_offset: '0,
                     record_offset: '0, append_offset: '0};
      priority if (slot_end >= AREA) begin
         result.status = ST_NO_TERM;
      end else if (word == ALL_ONES) begin
         if (!state_cur.have_record) begin
            result.status = ST_EMPTY;
         end else if (write_end > AREA) begin
            result.status        = ST_FOUND_FULL;
            result.record_offset = state_cur.last_offset;
         end else begin
            result.status        = ST_FOUND_ROOM;
            result.record_offset = state_cur.last_offset;
            result.append_offset = write_ofs[OFS_W-1:0];
         end
      end else if (word == magic) begin
         // advancing past the last usable slot ends the scan at once
         if (next_end >= AREA) begin
            result.status = ST_NO_TERM;
         end else begin
            result.status           = ST_CONTINUE;
            result.next_read_offset = slot_end[OFS_W-1:0];
            state_next.scan_offset  = slot_end[OFS_W-1:0];
            state_next.last_offset  = state_cur.scan_offset;
            state_next.have_record  = 1'b1;
         end
      end else begin
         result.status = ST_BAD_DELIM;
      end
   end

endmodule

### design/als_checker.sv
module als_checker import als_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input logic [2:0]       rsp_status,
   input logic [OFS_W-1:0] rsp_next_read_offset,
   input logic [OFS_W-1:0] rsp_record_offset,
   input logic [OFS_W-1:0] rsp_append_offset
);

   // stalled result word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_next_read_offset) && $stable(rsp_record_offset)
         && $stable(rsp_append_offset))
      else $error("stalled rsp word changed");

   // every final status restarts the scan at offset 0
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_CONTINUE |-> rsp_next_read_offset == '0)
      else $error("final status with nonzero next offset");

   // record offset only reported when a record was found
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_FOUND_ROOM && rsp_status != ST_FOUND_FULL
         |-> rsp_record_offset == '0)
      else $error("record offset without found status");

   // append slot lies past the last record
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_FOUND_ROOM |-> rsp_append_offset > rsp_record_offset)
      else $error("append offset not past record");

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp valid after reset");

endmodule

bind append_log_slot_scanner als_checker u_als_checker (
   .clock                (clock),
   .reset                (reset),
   .rsp_valid            (rsp_valid),
   .rsp_stall            (rsp_stall),
   .rsp_status           (rsp_status),
   .rsp_next_read_offset (rsp_next_read_offset),
   .rsp_record_offset    (rsp_record_offset),
   .rsp_append_offset    (rsp_append_offset)
);
